@@ src/gprm_pkg.sv @@
package gprm_pkg;

    // Number of analog axes and message slots per report
    localparam int NUM_ANALOG = 6;
    localparam int NUM_FACE   = 4;
    localparam int NUM_MENU   = 8;
    localparam int NUM_SLOTS  = NUM_ANALOG + 1 + NUM_FACE + NUM_MENU;

    // Slot positions in output order
    localparam int SLOT_HAT  = NUM_ANALOG;
    localparam int SLOT_FACE = SLOT_HAT + 1;
    localparam int SLOT_MENU = SLOT_FACE + NUM_FACE;

    // MIDI status bytes, channel 0
    localparam logic [7:0] ST_CC  = 8'hB0;
    localparam logic [7:0] ST_ON  = 8'h90;
    localparam logic [7:0] ST_OFF = 8'h80;

    localparam logic [6:0] VELOCITY = 7'd100;
    localparam logic [3:0] HAT_NONE = 4'd8;
    localparam int HAT_BASE  = 80;
    localparam int FACE_BASE = 50;
    localparam int MENU_BASE = 62;
    localparam int FACE_FIRST_BIT = 4;

    // One three-byte MIDI message
    typedef struct packed {
        logic [7:0] status;
        logic [6:0] data1;
        logic [6:0] data2;
    } msg_t;

endpackage

@@ src/gprm_cc_lane.sv @@
module gprm_cc_lane (
    input  logic [7:0] raw,
    input  logic [6:0] prev,
    input  logic       primed,
    output logic       fire,
    output logic [6:0] value
);

    // Halve the raw byte and flag a change against the stored value.
    assign value = raw[7:1];
    assign fire  = !primed || (value != prev);

endmodule

@@ src/gprm_note_lane.sv @@
module gprm_note_lane (
    input  logic       enable,
    input  logic       now_bit,
    input  logic       old_bit,
    output logic       fire,
    output logic [7:0] status
);
    import gprm_pkg::*;

    // A toggled button gives note-on when pressed and note-off when released.
    assign fire   = enable && (now_bit != old_bit);
    assign status = now_bit ? ST_ON : ST_OFF;

endmodule

@@ src/gprm_merge.sv @@
module gprm_merge (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  load,
    input  logic [gprm_pkg::NUM_SLOTS-1:0]        fire,
    input  gprm_pkg::msg_t                        msg [gprm_pkg::NUM_SLOTS],
    output logic                                  busy,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output gprm_pkg::msg_t                        m_msg,
    output logic                                  m_last
);
    import gprm_pkg::*;

    logic [NUM_SLOTS-1:0] pending_reg;
    logic [NUM_SLOTS-1:0] pending_next;
    msg_t                 slot_reg [NUM_SLOTS];
    logic                 valid_reg;
    logic                 valid_next;
    msg_t                 out_reg;
    msg_t                 out_next;
    logic                 last_reg;
    logic                 last_next;
    logic [NUM_SLOTS-1:0] pick;
    logic [NUM_SLOTS-1:0] remain;
    msg_t                 pick_msg;
    logic                 advance;

    // Lowest pending slot is the next message in report order.
    assign pick   = pending_reg & (~pending_reg + NUM_SLOTS'(1));
    assign remain = pending_reg & ~pick;

    always_comb
    begin
        pick_msg = '0;
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            if (pick[k])
            begin
                pick_msg = pick_msg | slot_reg[k];
            end
        end
    end

    assign advance = (!valid_reg || m_tready) && (pending_reg != '0);

    // Next-state for the pending mask and the output register.
    always_comb
    begin
        pending_next = pending_reg;
        valid_next   = valid_reg;
        out_next     = out_reg;
        last_next    = last_reg;
        if (load)
        begin
            pending_next = fire;
        end
        if (advance)
        begin
            pending_next = remain;
            valid_next   = 1'b1;
            out_next     = pick_msg;
            last_next    = (remain == '0);
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
            valid_reg   <= valid_next;
        end
    end

    // Message payloads need no reset.
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        last_reg <= last_next;
        if (load)
        begin
            for (int k = 0; k < NUM_SLOTS; k++)
            begin
                slot_reg[k] <= msg[k];
            end
        end
    end

    assign busy     = (pending_reg != '0);
    assign m_tvalid = valid_reg;
    assign m_msg    = out_reg;
    assign m_last   = last_reg;

endmodule

@@ src/gamepad_report_to_midi.sv @@
// Each report is stored in the slot registers and fed to the output register.
// Throughput: one message per cycle while m_tready is high; a report causing up
// to 19 messages holds the input until the single output register drains its slots.
// A report causing no message is taken every cycle while no slots are pending.
// Reset (rst_n low, asynchronous) clears the stored axes, buttons and the primed
// flag, so the first report sends all six control changes and only latches buttons.
module gamepad_report_to_midi (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // left_x, left_y, right_x, right_y, trigger_left, trigger_right,
    // buttons_a, buttons_b (8 bits each, lowest first)
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // midi_status [7:0], midi_data1 [14:8], midi_data2 [21:15], zero [23:22]
    output logic [23:0] m_tdata,
    output logic        m_tlast
);
    import gprm_pkg::*;

    logic                 primed_reg;
    logic [6:0]           prev_analog_reg [NUM_ANALOG];
    logic [7:0]           prev_buttons_a_reg;
    logic [7:0]           prev_buttons_b_reg;
    logic                 accept;
    logic                 busy;
    logic [NUM_SLOTS-1:0] fire;
    msg_t                 msg [NUM_SLOTS];
    logic [6:0]           halved [NUM_ANALOG];
    logic [7:0]           buttons_a;
    logic [7:0]           buttons_b;
    logic [3:0]           new_hat;
    logic [3:0]           old_hat;
    logic [3:0]           hat_code;
    logic                 hat_on;
    msg_t                 out_msg;
    logic                 out_last;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = !busy;
    assign buttons_a = s_tdata[55:48];
    assign buttons_b = s_tdata[63:56];

    // Control change lanes, one per analog axis.
    for (genvar i = 0; i < NUM_ANALOG; i++)
    begin : g_cc
        gprm_cc_lane u_cc (
            .raw    (s_tdata[8*i +: 8]),
            .prev   (prev_analog_reg[i]),
            .primed (primed_reg),
            .fire   (fire[i]),
            .value  (halved[i])
        );
        assign msg[i] = '{status: ST_CC, data1: 7'(i + 1), data2: halved[i]};
    end

    // Hat: note-on for a new direction, note-off for the old one on release.
    assign new_hat   = buttons_a[3:0];
    assign old_hat   = prev_buttons_a_reg[3:0];
    assign hat_on    = (new_hat != HAT_NONE);
    assign hat_code  = hat_on ? new_hat : old_hat;
    assign fire[SLOT_HAT] = primed_reg && (new_hat != old_hat);
    assign msg[SLOT_HAT]  = '{status: hat_on ? ST_ON : ST_OFF,
                              data1: 7'(HAT_BASE + 2) + {2'b00, hat_code, 1'b0},
                              data2: VELOCITY};

    // Face button lanes, buttons_a upper nibble.
    for (genvar k = 0; k < NUM_FACE; k++)
    begin : g_face
        localparam int Bit  = FACE_FIRST_BIT + k;
        localparam int Note = FACE_BASE + 2 * (Bit + 1);
        logic [7:0] st;
        gprm_note_lane u_note (
            .enable  (primed_reg),
            .now_bit (buttons_a[Bit]),
            .old_bit (prev_buttons_a_reg[Bit]),
            .fire    (fire[SLOT_FACE + k]),
            .status  (st)
        );
        assign msg[SLOT_FACE + k] = '{status: st, data1: 7'(Note), data2: VELOCITY};
    end

    // Shoulder and menu button lanes, buttons_b.
    for (genvar k = 0; k < NUM_MENU; k++)
    begin : g_menu
        localparam int Note = MENU_BASE + 2 * (k + 1);
        logic [7:0] st;
        gprm_note_lane u_note (
            .enable  (primed_reg),
            .now_bit (buttons_b[k]),
            .old_bit (prev_buttons_b_reg[k]),
            .fire    (fire[SLOT_MENU + k]),
            .status  (st)
        );
        assign msg[SLOT_MENU + k] = '{status: st, data1: 7'(Note), data2: VELOCITY};
    end

    // Report state is updated as each item is accepted.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg         <= 1'b0;
            prev_buttons_a_reg <= '0;
            prev_buttons_b_reg <= '0;
            for (int i = 0; i < NUM_ANALOG; i++)
            begin
                prev_analog_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            primed_reg         <= 1'b1;
            prev_buttons_a_reg <= buttons_a;
            prev_buttons_b_reg <= buttons_b;
            for (int i = 0; i < NUM_ANALOG; i++)
            begin
                prev_analog_reg[i] <= halved[i];
            end
        end
    end

    // Merge stage drains the firing slots in order.
    gprm_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .fire     (fire),
        .msg      (msg),
        .busy     (busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_msg    (out_msg),
        .m_last   (out_last)
    );

    assign m_tdata = {2'b00, out_msg.data2, out_msg.data1, out_msg.status};
    assign m_tlast = out_last;

    // A message that is not the last of its report leaves more slots pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> busy)
        else $error("non-final message shown with no slots pending");

    // The first report after reset leaves its six control changes pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !primed_reg) |=> busy)
        else $error("first report produced no pending messages");

    // Any accepted item primes the block.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> primed_reg)
        else $error("primed flag not set after an item");

endmodule
